// ----- rtl/core/gotp_pkg.sv -----
// Shared types, codes and helper functions for the glyph outline to path block.
package gotp_pkg;

    // Point tags on the input stream.
    localparam logic [1:0] TAG_CONIC   = 2'd0;
    localparam logic [1:0] TAG_ON      = 2'd1;
    localparam logic [1:0] TAG_CUBIC   = 2'd2;
    localparam logic [1:0] TAG_IGNORED = 2'd3;

    // Segment kinds on the output stream.
    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_QUAD  = 2'd2;
    localparam logic [1:0] KIND_CUBIC = 2'd3;

    // Configuration register map.
    localparam int unsigned PADDR_W   = 3;
    localparam logic [PADDR_W-1:0] ADDR_COORD_SCALE = 3'd0;
    localparam int unsigned SCALE_W   = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;

    // One scaled point in signed Q23.8.
    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_point;

    // One path segment as it leaves the block.
    typedef struct packed {
        logic [1:0] kind;
        t_point     pt_end;
        t_point     pt_ctrl;
        t_point     pt_ctrl2;
        logic       last;
    } t_result;

    // Midpoint of two Q23.8 values, rounded toward negative infinity.
    // The halved sum always fits in 32 bits, so no saturation is needed.
    function automatic logic signed [31:0] f_mid(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] sum;
        sum = {a[31], a} + {b[31], b};
        return sum[32:1];
    endfunction

    function automatic t_point f_mid_pt(input t_point a, input t_point b);
        t_point r;
        r.x = f_mid(a.x, b.x);
        r.y = f_mid(a.y, b.y);
        return r;
    endfunction

endpackage

// ----- rtl/core/gotp_scale.sv -----
// Scales a font-unit point by the Q8.16 coordinate scale into saturated Q23.8.
module gotp_scale import gotp_pkg::*; (
    input  logic signed [15:0]        i_x,
    input  logic signed [15:0]        i_y,
    input  logic        [SCALE_W-1:0] i_scale,
    output t_point                    o_pt
);

    logic signed [40:0] prod_x;
    logic signed [40:0] prod_y;

    // Clamp a 33-bit signed value to the 32-bit range.
    function automatic logic signed [31:0] f_sat(input logic [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Signed coordinate times unsigned scale; one multiplier per axis.
    assign prod_x = $signed(i_x) * $signed({1'b0, i_scale});
    assign prod_y = $signed(i_y) * $signed({1'b0, i_scale});

    // Dropping the low eight bits is a floor shift on two's complement.
    assign o_pt.x = f_sat(prod_x[40:8]);
    assign o_pt.y = f_sat(prod_y[40:8]);

endmodule

// ----- rtl/core/glyph_outline_to_path.sv -----
// A point passes the input register, the scaled point register and the result queue.
// Throughput: one point per cycle when the output keeps up; a two-segment point waits for room.
// The scale multipliers sit between the input register and the point register.
// A two-entry result queue lets a new point enter while a segment waits on the output.
// Reset (synchronous, active low) empties the pipeline, clears pending points,
// arms the next point to open a contour and restores coord_scale to 1.0.
module glyph_outline_to_path import gotp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Point input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [15:0] point_x, [31:16] point_y
    input  logic [1:0]           s_axis_tuser,   // [1:0] point_tag
    input  logic                 s_axis_tlast,   // contour_last
    // Segment output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] end_x, [63:32] end_y, [95:64] ctrl_x, [127:96] ctrl_y,
    // [159:128] ctrl2_x, [191:160] ctrl2_y
    output logic [191:0]         m_axis_tdata,
    output logic [1:0]           m_axis_tuser,   // [1:0] segment_kind
    output logic                 m_axis_tlast,   // run_last
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_CONIC  = 2'd1,
        PEND_CUBIC1 = 2'd2,
        PEND_CUBIC2 = 2'd3
    } t_pend;

    localparam t_point PT_ZERO = '0;

    // Configuration register.
    logic [SCALE_W-1:0] r_scale;

    // Input register stage.
    logic               r_a_valid;
    logic signed [15:0] r_a_x;
    logic signed [15:0] r_a_y;
    logic [1:0]         r_a_tag;
    logic               r_a_last;

    // Scaled point stage.
    logic               r_b_valid;
    t_point             r_b_pt;
    logic [1:0]         r_b_tag;
    logic               r_b_last;
    t_point             scaled_pt;

    // Contour state.
    t_pend              r_pend, n_pend;
    t_point             r_pa, n_pa;
    t_point             r_pb, n_pb;
    t_point             r_start, n_start;
    logic               r_start_on, n_start_on;
    logic               r_at_start, n_at_start;

    // Results of the point in the scaled stage.
    t_result            res0, res1;
    logic [1:0]         res_cnt;

    // Result queue.
    t_result            r_q [0:1];
    t_result            n_q [0:1];
    logic [1:0]         r_cnt, n_cnt;
    logic               pop;
    logic [1:0]         cnt_after_pop;
    logic               b_adv;
    logic               a_adv;
    logic               in_take;

    // Configuration access; writes to other addresses are dropped.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COORD_SCALE) ? {8'b0, r_scale} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_COORD_SCALE) begin
            r_scale <= pwdata[SCALE_W-1:0];
        end
    end

    // Handshake flow between the stages.
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign cnt_after_pop = r_cnt - {1'b0, pop};
    assign b_adv         = r_b_valid && ({1'b0, cnt_after_pop} + {1'b0, res_cnt} <= 3'd2);
    assign a_adv         = r_a_valid && (!r_b_valid || b_adv);
    assign s_axis_tready = !r_a_valid || a_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
        if (in_take) begin
            r_a_x    <= s_axis_tdata[15:0];
            r_a_y    <= s_axis_tdata[31:16];
            r_a_tag  <= s_axis_tuser;
            r_a_last <= s_axis_tlast;
        end
    end

    gotp_scale u_scale (
        .i_x     (r_a_x),
        .i_y     (r_a_y),
        .i_scale (r_scale),
        .o_pt    (scaled_pt)
    );

    // Scaled point register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
        if (a_adv) begin
            r_b_pt   <= scaled_pt;
            r_b_tag  <= r_a_tag;
            r_b_last <= r_a_last;
        end
    end

    // Segment decisions for the current point and the next contour state.
    always_comb begin
        t_result new_res;
        logic    has_new;
        logic    handled;
        t_point  close_end;

        n_pend     = r_pend;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_start    = r_start;
        n_start_on = r_start_on;
        n_at_start = r_at_start;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;
        new_res    = '0;
        has_new    = 1'b0;
        handled    = 1'b0;
        close_end  = r_start_on ? r_start : f_mid_pt(r_b_pt, r_start);

        if (r_at_start) begin
            // Whatever its tag, the opening point moves the pen.
            res0.kind   = KIND_MOVE;
            res0.pt_end = r_b_pt;
            res_cnt     = 2'd1;
            n_start     = r_b_pt;
            n_start_on  = (r_b_tag == TAG_ON);
            n_pend      = PEND_NONE;
            n_at_start  = r_b_last;
        end else begin
            // Finish whatever the previous points left open.
            unique case (r_pend)
                PEND_CONIC: begin
                    res0.kind    = KIND_QUAD;
                    res0.pt_ctrl = r_pa;
                    if (r_b_tag == TAG_ON) begin
                        res0.pt_end = r_b_pt;
                        handled     = 1'b1;
                    end else begin
                        res0.pt_end = f_mid_pt(r_pa, r_b_pt);
                    end
                    res_cnt = 2'd1;
                    n_pend  = PEND_NONE;
                end
                PEND_CUBIC1: begin
                    if (r_b_last) begin
                        n_pend = PEND_NONE;
                    end else begin
                        n_pb    = r_b_pt;
                        n_pend  = PEND_CUBIC2;
                        handled = 1'b1;
                    end
                end
                PEND_CUBIC2: begin
                    res0.kind     = KIND_CUBIC;
                    res0.pt_end   = r_b_pt;
                    res0.pt_ctrl  = r_pa;
                    res0.pt_ctrl2 = r_pb;
                    res_cnt       = 2'd1;
                    n_pend        = PEND_NONE;
                    handled       = 1'b1;
                end
                PEND_NONE: begin
                end
            endcase

            // The point on its own terms, unless it was used up above.
            if (!handled) begin
                priority if (r_b_tag == TAG_ON) begin
                    new_res.kind   = KIND_LINE;
                    new_res.pt_end = r_b_pt;
                    has_new        = 1'b1;
                end else if (r_b_tag == TAG_CONIC) begin
                    if (r_b_last) begin
                        // Close the contour to its first point, or to the midpoint if that point is off-curve.
                        new_res.kind    = KIND_QUAD;
                        new_res.pt_end  = close_end;
                        new_res.pt_ctrl = r_b_pt;
                        has_new         = 1'b1;
                    end else begin
                        n_pa   = r_b_pt;
                        n_pend = PEND_CONIC;
                    end
                end else if (r_b_tag == TAG_CUBIC) begin
                    if (!r_b_last) begin
                        n_pa   = r_b_pt;
                        n_pend = PEND_CUBIC1;
                    end
                end else begin
                    // An ignored point produces nothing.
                end
            end

            if (has_new) begin
                if (res_cnt == 2'd0) begin
                    res0 = new_res;
                end else begin
                    res1 = new_res;
                end
                res_cnt = res_cnt + 2'd1;
            end

            if (r_b_last) begin
                n_at_start = 1'b1;
                n_pend     = PEND_NONE;
            end
        end

        res0.last = (res_cnt == 2'd1);
        res1.last = (res_cnt == 2'd2);
    end

    // Contour state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= PEND_NONE;
            r_pa       <= PT_ZERO;
            r_pb       <= PT_ZERO;
            r_start    <= PT_ZERO;
            r_start_on <= 1'b0;
            r_at_start <= 1'b1;
        end else if (b_adv) begin
            r_pend     <= n_pend;
            r_pa       <= n_pa;
            r_pb       <= n_pb;
            r_start    <= n_start;
            r_start_on <= n_start_on;
            r_at_start <= n_at_start;
        end
    end

    // Result queue: shift out on a transaction, append the new segments behind.
    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = cnt_after_pop;
        if (b_adv) begin
            if (res_cnt == 2'd2) begin
                n_q[0] = res0;
                n_q[1] = res1;
            end else if (res_cnt == 2'd1) begin
                if (cnt_after_pop == 2'd0) begin
                    n_q[0] = res0;
                end else begin
                    n_q[1] = res0;
                end
            end
            n_cnt = cnt_after_pop + res_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    // Output stream driven from the queue head.
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = r_q[0].kind;
    assign m_axis_tlast  = r_q[0].last;
    assign m_axis_tdata  = {r_q[0].pt_ctrl2.y, r_q[0].pt_ctrl2.x,
                            r_q[0].pt_ctrl.y,  r_q[0].pt_ctrl.x,
                            r_q[0].pt_end.y,   r_q[0].pt_end.x};

`ifndef SYNTH
    // The queue never holds more than its two entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overflow");

    // A contour that is about to open has nothing pending.
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> r_pend == PEND_NONE)
        else $error("pending point at contour start");

    // A point that ends its contour arms the next contour.
    a_last_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && r_b_last) |=> r_at_start)
        else $error("contour end did not rearm start");

    // Two segments from one point are only taken into an empty queue.
    a_two_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && res_cnt == 2'd2) |-> cnt_after_pop == 2'd0)
        else $error("two segments pushed without room");
`endif

endmodule

// ----- sim/glyph_outline_to_path_tb.sv -----
// Self-checking testbench for glyph_outline_to_path: outline points in, path segments out.
`timescale 1ns / 1ps

module glyph_outline_to_path_tb;
    import gotp_pkg::*;

    localparam int IDLE_PCT     = 9;
    localparam int PHASE_POINTS = 220;
    localparam int SETTLE_CYCLES = 10;
    // Index four of the register map has no register behind it.
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    // One outline point as it enters the block.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         tag;
        logic               last;
    } t_outline_pt;

    // What the path tracer holds between points.
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_CONIC,
        PEND_CUBIC_FIRST,
        PEND_CUBIC_BOTH
    } t_tb_pend;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;  // [15:0] point_x, [31:16] point_y
    logic [1:0]           s_axis_tuser = '0;  // [1:0] point_tag
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [31:0] end_x, [63:32] end_y, [95:64] ctrl_x, [127:96] ctrl_y,
    // [159:128] ctrl2_x, [191:160] ctrl2_y
    logic [191:0]         m_axis_tdata;
    logic [1:0]           m_axis_tuser;       // [1:0] segment_kind
    logic                 m_axis_tlast;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    t_outline_pt point_queue[$];
    t_outline_pt drive_pt;
    t_result     seg_expect[$];
    int          mismatches = 0;
    logic        calm = 1'b0;

    // Path tracer state mirrored from the block.
    logic [SCALE_W-1:0] scale_q = SCALE_RESET;
    t_tb_pend           pend = PEND_NONE;
    t_point             pend_a = '0;
    t_point             pend_b = '0;
    t_point             start_pt = '0;
    logic               start_on = 1'b0;
    logic               opening = 1'b1;

    glyph_outline_to_path dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Scaled coordinate in Q23.8: floor(c * scale / 256), saturated to 32 bits.
    function automatic logic signed [31:0] scale_coord(input logic signed [15:0] c);
        longint prod;
        prod = (longint'(c) * longint'(scale_q)) >>> 8;
        if (prod > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (prod < -64'sd2147483648) return 32'sh80000000;
        return prod[31:0];
    endfunction

    // Midpoint of two Q23.8 points, each axis rounded toward negative infinity.
    function automatic t_point mid_point(input t_point a, input t_point b);
        t_point r;
        longint sx;
        longint sy;
        sx = (longint'(a.x) + longint'(b.x)) >>> 1;
        sy = (longint'(a.y) + longint'(b.y)) >>> 1;
        r.x = sx[31:0];
        r.y = sy[31:0];
        return r;
    endfunction

    task automatic push_segment(input logic [1:0] kind, input t_point e,
                                input t_point c, input t_point c2);
        t_result r;
        r.kind = kind;
        r.pt_end = e;
        r.pt_ctrl = c;
        r.pt_ctrl2 = c2;
        r.last = 1'b0;
        seg_expect.insert(seg_expect.size(), r);
    endtask

    // Advances the tracer by one point and queues the segments it closes.
    task automatic trace_point(input t_outline_pt pt);
        t_point  p;
        t_point  e;
        t_point  zero_pt;
        t_result tail;
        int      n0;
        logic    taken;
        n0 = seg_expect.size();
        zero_pt = '0;
        taken = 1'b0;
        p.x = scale_coord(pt.x);
        p.y = scale_coord(pt.y);
        if (opening) begin
            push_segment(KIND_MOVE, p, zero_pt, zero_pt);
            start_pt = p;
            start_on = (pt.tag == TAG_ON);
            pend = PEND_NONE;
            opening = pt.last;
        end else begin
            // Finish whatever an earlier control point left open.
            case (pend)
                PEND_CONIC: begin
                    if (pt.tag == TAG_ON) begin
                        push_segment(KIND_QUAD, p, pend_a, zero_pt);
                        taken = 1'b1;
                    end else begin
                        push_segment(KIND_QUAD, mid_point(pend_a, p), pend_a, zero_pt);
                    end
                    pend = PEND_NONE;
                end
                PEND_CUBIC_FIRST: begin
                    if (pt.last) begin
                        pend = PEND_NONE;
                    end else begin
                        pend_b = p;
                        pend = PEND_CUBIC_BOTH;
                        taken = 1'b1;
                    end
                end
                PEND_CUBIC_BOTH: begin
                    push_segment(KIND_CUBIC, p, pend_a, pend_b);
                    pend = PEND_NONE;
                    taken = 1'b1;
                end
                default: begin
                end
            endcase
            // A point not consumed above acts on its own tag.
            if (!taken) begin
                case (pt.tag)
                    TAG_ON: begin
                        push_segment(KIND_LINE, p, zero_pt, zero_pt);
                    end
                    TAG_CONIC: begin
                        if (pt.last) begin
                            e = start_on ? start_pt : mid_point(p, start_pt);
                            push_segment(KIND_QUAD, e, p, zero_pt);
                        end else begin
                            pend_a = p;
                            pend = PEND_CONIC;
                        end
                    end
                    TAG_CUBIC: begin
                        if (!pt.last) begin
                            pend_a = p;
                            pend = PEND_CUBIC_FIRST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (pt.last) begin
                opening = 1'b1;
                pend = PEND_NONE;
            end
        end
        if (seg_expect.size() > n0) begin
            tail = seg_expect.pop_back();
            tail.last = 1'b1;
            seg_expect.insert(seg_expect.size(), tail);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: presents queued points, idling now and then between transactions unless calm is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (point_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                drive_pt = point_queue.pop_front();
                s_axis_tdata <= {drive_pt.y, drive_pt.x};
                s_axis_tuser <= drive_pt.tag;
                s_axis_tlast <= drive_pt.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Segment receiver stalls at random unless calm is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: checks each segment transaction, then updates the tracer from
    // accepted points and register writes.
    always @(posedge i_clk) begin
        t_result     want;
        t_outline_pt seen;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (seg_expect.size() == 0) begin
                    $error("segment with no expectation: kind %0d", m_axis_tuser);
                    mismatches++;
                end else begin
                    want = seg_expect.pop_front();
                    check_field("segment_kind", want.kind, m_axis_tuser);
                    check_field("end_x", want.pt_end.x, m_axis_tdata[31:0]);
                    check_field("end_y", want.pt_end.y, m_axis_tdata[63:32]);
                    check_field("ctrl_x", want.pt_ctrl.x, m_axis_tdata[95:64]);
                    check_field("ctrl_y", want.pt_ctrl.y, m_axis_tdata[127:96]);
                    check_field("ctrl2_x", want.pt_ctrl2.x, m_axis_tdata[159:128]);
                    check_field("ctrl2_y", want.pt_ctrl2.y, m_axis_tdata[191:160]);
                    check_field("run_last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.x = s_axis_tdata[15:0];
                seen.y = s_axis_tdata[31:16];
                seen.tag = s_axis_tuser;
                seen.last = s_axis_tlast;
                trace_point(seen);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_COORD_SCALE) begin
                scale_q = pwdata[SCALE_W-1:0];
            end
        end
    end

    task automatic add_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [1:0] tag, input logic last);
        t_outline_pt pt;
        pt.x = x;
        pt.y = y;
        pt.tag = tag;
        pt.last = last;
        point_queue.insert(point_queue.size(), pt);
    endtask

    // Mostly full-range values, sometimes the extremes, zero and minus one.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One contour built mostly from well-formed segment groups, with some
    // stray points; returns the number of points queued.
    task automatic add_contour(output int count);
        logic [1:0] tags[$];
        int groups;
        tags.insert(tags.size(), 2'($urandom_range(0, 3)));
        groups = $urandom_range(0, 6);
        for (int g = 0; g < groups; g++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: tags.insert(tags.size(), TAG_ON);
                3, 4: begin
                    tags.insert(tags.size(), TAG_CONIC);
                    tags.insert(tags.size(), TAG_ON);
                end
                5: begin
                    tags.insert(tags.size(), TAG_CONIC);
                    tags.insert(tags.size(), TAG_CONIC);
                end
                6, 7: begin
                    tags.insert(tags.size(), TAG_CUBIC);
                    tags.insert(tags.size(), TAG_CUBIC);
                    tags.insert(tags.size(), TAG_ON);
                end
                default: tags.insert(tags.size(), 2'($urandom_range(0, 3)));
            endcase
        end
        foreach (tags[i]) begin
            add_point(rand_coord(), rand_coord(), tags[i], i == tags.size() - 1);
        end
        count = tags.size();
    endtask

    task automatic add_random_points(input int target);
        int n;
        int c;
        n = 0;
        while (n < target) begin
            add_contour(c);
            n += c;
        end
    endtask

    // Waits until every point is taken and every segment has arrived, then
    // lets the pipeline empty out.
    task automatic drain();
        do @(negedge i_clk);
        while (point_queue.size() != 0 || s_axis_tvalid || seg_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [23:0] scale_plan[5];
        scale_plan[0] = 24'hFFFFFF;
        scale_plan[1] = 24'h000000;
        scale_plan[2] = 24'($urandom_range(0, 24'hFFFFFF));
        scale_plan[3] = 24'h000100;
        scale_plan[4] = 24'($urandom_range(24'h010000, 24'h040000));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed contours at the reset scale.
        // Lines at the coordinate extremes, conic closed by an on point,
        // conic chains ending at midpoints, a stray point after a conic,
        // a full cubic and a conic closing to an on-curve start.
        add_point(16'sd0, 16'sd0, TAG_ON, 1'b0);
        add_point(16'sd32767, -16'sd32768, TAG_ON, 1'b0);
        add_point(-16'sd32768, 16'sd32767, TAG_CONIC, 1'b0);
        add_point(16'sd100, 16'sd200, TAG_ON, 1'b0);
        add_point(16'sd10, 16'sd10, TAG_CONIC, 1'b0);
        add_point(-16'sd20, 16'sd31, TAG_CONIC, 1'b0);
        add_point(16'sd5, -16'sd5, TAG_IGNORED, 1'b0);
        add_point(16'sd1, 16'sd2, TAG_CUBIC, 1'b0);
        add_point(16'sd3, 16'sd4, TAG_CONIC, 1'b0);
        add_point(16'sd7, 16'sd8, TAG_ON, 1'b0);
        add_point(-16'sd7, 16'sd9, TAG_CONIC, 1'b1);
        // Ignored tag opens a contour; a cubic with one point left is dropped.
        add_point(-16'sd3, -16'sd5, TAG_IGNORED, 1'b0);
        add_point(16'sd9, -16'sd1, TAG_CUBIC, 1'b0);
        add_point(16'sd11, 16'sd11, TAG_ON, 1'b1);
        // Conic closing to an off-curve start through the midpoint.
        add_point(16'sd1, 16'sd1, TAG_CONIC, 1'b0);
        add_point(-16'sd1, 16'sd3, TAG_CONIC, 1'b1);
        // Single-point contour.
        add_point(16'sd32767, 16'sd32767, TAG_ON, 1'b1);
        // Cubic as the second-to-last point and as the last point.
        add_point(16'sd0, 16'sd0, TAG_ON, 1'b0);
        add_point(16'sd2, 16'sd2, TAG_CUBIC, 1'b0);
        add_point(16'sd4, 16'sd4, TAG_CUBIC, 1'b1);
        // Cubic opening, conic ended by an ignored point, closing conic.
        add_point(-16'sd32768, -16'sd32768, TAG_CUBIC, 1'b0);
        add_point(16'sd1, 16'sd1, TAG_CONIC, 1'b0);
        add_point(-16'sd1, -16'sd1, TAG_IGNORED, 1'b0);
        add_point(16'sd3, 16'sd3, TAG_CONIC, 1'b1);
        // Pending conic followed by a closing conic gives two segments.
        add_point(16'sd0, 16'sd0, TAG_ON, 1'b0);
        add_point(16'sd5, 16'sd5, TAG_CONIC, 1'b0);
        add_point(16'sd6, -16'sd6, TAG_CONIC, 1'b1);
        drain();

        // Random contours under a range of scales.
        foreach (scale_plan[i]) begin
            if (i == 2) begin
                apb_write(ADDR_UNMAPPED, $urandom);
            end
            apb_write(ADDR_COORD_SCALE, {8'h00, scale_plan[i]});
            calm = (i == 2);
            add_random_points(PHASE_POINTS);
            drain();
        end

        if (mismatches == 0) begin
            $display("[glyph_outline_to_path] OK");
        end else begin
            $display("[glyph_outline_to_path] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a missing segment.
    initial begin
        #400000;
        $display("[glyph_outline_to_path] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gotp_pkg.sv
rtl/core/gotp_scale.sv
rtl/core/glyph_outline_to_path.sv
sim/glyph_outline_to_path_tb.sv
